@@ rtl/core/jcr_pkg.sv @@
// Shared types, character codes and the byte classifier for the JSON recognizer.
package jcr_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [3:0] {
    C_LBRACE,
    C_RBRACE,
    C_LBRACK,
    C_RBRACK,
    C_COLON,
    C_COMMA,
    C_QUOTE,
    C_CTRL,
    C_ALNUM,
    C_OTHER
  } cls_e;

  typedef enum logic [3:0] {
    H_START  = 4'd0,
    H_QUOTE  = 4'd1,
    H_COLON  = 4'd2,
    H_COMMA  = 4'd3,
    H_LBRACE = 4'd4,
    H_RBRACE = 4'd5,
    H_LBRACK = 4'd6,
    H_RBRACK = 4'd7,
    H_LETTER = 4'd8,
    H_CTRL   = 4'd9
  } handler_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_BEGIN      = 5'd1,
    PH_NAME_BEGIN = 5'd2,
    PH_NAME       = 5'd3,
    PH_NAME_END   = 5'd4,
    PH_VAL_BEGIN  = 5'd5,
    PH_STR_BEGIN  = 5'd6,
    PH_STRING     = 5'd7,
    PH_STR_END    = 5'd8,
    PH_OBJ_BEGIN  = 5'd9,
    PH_OBJ        = 5'd10,
    PH_OBJ_END    = 5'd11,
    PH_ARR_BEGIN  = 5'd12,
    PH_ARR        = 5'd13,
    PH_ARR_END    = 5'd14,
    PH_VAL_END    = 5'd15,
    PH_END        = 5'd16
  } phase_e;

  typedef enum logic [1:0] {
    V_FALSE = 2'd0,
    V_TRUE  = 2'd1,
    V_INDET = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    T_NONE   = 2'd0,
    T_STRING = 2'd1,
    T_OBJECT = 2'd2,
    T_ARRAY  = 2'd3
  } vtype_e;

  // one classified beat as it travels through the queue
  typedef struct packed {
    logic valid;
    cls_e cls;
  } beat_t;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if (c == CH_LBRACE) begin
      r = C_LBRACE;
    end else if (c == CH_RBRACE) begin
      r = C_RBRACE;
    end else if (c == CH_LBRACK) begin
      r = C_LBRACK;
    end else if (c == CH_RBRACK) begin
      r = C_RBRACK;
    end else if (c == CH_COLON) begin
      r = C_COLON;
    end else if (c == CH_COMMA) begin
      r = C_COMMA;
    end else if (c == CH_QUOTE) begin
      r = C_QUOTE;
    end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
      r = C_CTRL;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h30 && c <= 8'h39)) begin
      r = C_ALNUM;
    end else begin
      r = C_OTHER;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/jcr_front.sv @@
// Front end: takes input beats and classifies each byte for the queue.
module jcr_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     char_in_i,
  input  logic           q_full_i,
  output jcr_pkg::beat_t push_o
);

  assign in_stall_o   = q_full_i;
  assign push_o.valid = in_valid_i && !q_full_i;
  assign push_o.cls   = jcr_pkg::classify(char_in_i);

endmodule

@@ rtl/core/jcr_queue.sv @@
// Short FIFO of classified beats between front and back end.
module jcr_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jcr_pkg::beat_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output jcr_pkg::beat_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jcr_pkg::cls_e     mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cls   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cls;
    end
  end

endmodule

@@ rtl/core/jcr_back.sv @@
// Back end: grammar state update per classified beat, held as the result register.
module jcr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jcr_pkg::beat_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     verdict_o,
  output logic [4:0]     phase_o,
  output logic [1:0]     value_type_o,
  output logic [3:0]     expect_class_o
);

  jcr_pkg::handler_e h_q, h_d;
  jcr_pkg::phase_e   p_q, p_d;
  jcr_pkg::vtype_e   t_q, t_d;
  jcr_pkg::verdict_e v_q, v_d;
  logic              out_valid_q, out_valid_d;
  jcr_pkg::verdict_e v_body;

  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  // inside an object or array body stray bytes are accepted
  assign v_body = (p_q == jcr_pkg::PH_OBJ || p_q == jcr_pkg::PH_ARR) ?
                  jcr_pkg::V_TRUE : jcr_pkg::V_FALSE;

  always_comb begin
    h_d = h_q;
    p_d = p_q;
    t_d = t_q;
    v_d = v_q;
    unique case (h_q)
      jcr_pkg::H_QUOTE: begin
        unique case (head_i.cls)
          jcr_pkg::C_COLON: begin
            h_d = jcr_pkg::H_COLON;
            if (p_q == jcr_pkg::PH_NAME_END) begin
              p_d = jcr_pkg::PH_VAL_BEGIN;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = (p_q == jcr_pkg::PH_OBJ) ? jcr_pkg::V_TRUE : jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_COMMA: begin
            h_d = jcr_pkg::H_COMMA;
            if (p_q == jcr_pkg::PH_STR_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = v_body;
            end
          end
          jcr_pkg::C_RBRACE: begin
            h_d = jcr_pkg::H_RBRACE;
            if (p_q == jcr_pkg::PH_OBJ) begin
              p_d = jcr_pkg::PH_OBJ_END;
              v_d = jcr_pkg::V_TRUE;
            end else if (p_q == jcr_pkg::PH_STR_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_RBRACK: begin
            h_d = jcr_pkg::H_RBRACK;
            if (p_q == jcr_pkg::PH_ARR) begin
              p_d = jcr_pkg::PH_ARR_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_ALNUM: begin
            h_d = jcr_pkg::H_LETTER;
            if (p_q == jcr_pkg::PH_NAME_BEGIN) begin
              p_d = jcr_pkg::PH_NAME;
              v_d = jcr_pkg::V_TRUE;
            end else if (p_q == jcr_pkg::PH_STR_BEGIN) begin
              p_d = jcr_pkg::PH_STRING;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = v_body;
            end
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
      jcr_pkg::H_COLON: begin
        unique case (head_i.cls)
          jcr_pkg::C_QUOTE: begin
            h_d = jcr_pkg::H_QUOTE;
            if (p_q == jcr_pkg::PH_VAL_BEGIN) begin
              t_d = jcr_pkg::T_STRING;
              p_d = jcr_pkg::PH_STR_BEGIN;
              v_d = jcr_pkg::V_TRUE;
            end
          end
          jcr_pkg::C_LBRACE: begin
            h_d = jcr_pkg::H_LBRACE;
            if (p_q == jcr_pkg::PH_VAL_BEGIN) begin
              t_d = jcr_pkg::T_OBJECT;
              p_d = jcr_pkg::PH_OBJ_BEGIN;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_LBRACK: begin
            h_d = jcr_pkg::H_LBRACK;
            if (p_q == jcr_pkg::PH_VAL_BEGIN) begin
              t_d = jcr_pkg::T_ARRAY;
              p_d = jcr_pkg::PH_ARR_BEGIN;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
      jcr_pkg::H_COMMA: begin
        if (head_i.cls == jcr_pkg::C_QUOTE) begin
          h_d = jcr_pkg::H_QUOTE;
          if (p_q == jcr_pkg::PH_VAL_END) begin
            p_d = jcr_pkg::PH_NAME_BEGIN;
            v_d = jcr_pkg::V_TRUE;
          end else begin
            v_d = v_body;
          end
        end else begin
          v_d = jcr_pkg::V_FALSE;
        end
      end
      jcr_pkg::H_LBRACE: begin
        if (head_i.cls == jcr_pkg::C_QUOTE) begin
          h_d = jcr_pkg::H_QUOTE;
          if (p_q == jcr_pkg::PH_BEGIN) begin
            p_d = jcr_pkg::PH_NAME_BEGIN;
            v_d = jcr_pkg::V_TRUE;
          end else if (p_q == jcr_pkg::PH_OBJ_BEGIN) begin
            p_d = jcr_pkg::PH_OBJ;
            v_d = jcr_pkg::V_TRUE;
          end else begin
            v_d = jcr_pkg::V_FALSE;
          end
        end else begin
          v_d = jcr_pkg::V_FALSE;
        end
      end
      jcr_pkg::H_RBRACE: begin
        unique case (head_i.cls)
          jcr_pkg::C_COMMA: begin
            h_d = jcr_pkg::H_COMMA;
            if (p_q == jcr_pkg::PH_OBJ_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_RBRACE: begin
            h_d = jcr_pkg::H_RBRACE;
            if (p_q == jcr_pkg::PH_OBJ_END || p_q == jcr_pkg::PH_ARR_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          jcr_pkg::C_CTRL: begin
            h_d = jcr_pkg::H_CTRL;
            if (p_q == jcr_pkg::PH_VAL_END) begin
              p_d = jcr_pkg::PH_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
      jcr_pkg::H_LBRACK: begin
        if (head_i.cls == jcr_pkg::C_QUOTE) begin
          h_d = jcr_pkg::H_QUOTE;
          if (p_q == jcr_pkg::PH_ARR_BEGIN) begin
            p_d = jcr_pkg::PH_ARR;
            v_d = jcr_pkg::V_TRUE;
          end else begin
            v_d = jcr_pkg::V_FALSE;
          end
        end else begin
          v_d = jcr_pkg::V_FALSE;
        end
      end
      jcr_pkg::H_RBRACK: begin
        unique case (head_i.cls)
          jcr_pkg::C_COMMA: begin
            h_d = jcr_pkg::H_COMMA;
            if (p_q == jcr_pkg::PH_ARR_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end
          end
          jcr_pkg::C_RBRACE: begin
            h_d = jcr_pkg::H_RBRACE;
            if (p_q == jcr_pkg::PH_ARR_END) begin
              p_d = jcr_pkg::PH_VAL_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = jcr_pkg::V_FALSE;
            end
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
      jcr_pkg::H_LETTER: begin
        unique case (head_i.cls)
          jcr_pkg::C_QUOTE: begin
            h_d = jcr_pkg::H_QUOTE;
            if (p_q == jcr_pkg::PH_NAME) begin
              p_d = jcr_pkg::PH_NAME_END;
              v_d = jcr_pkg::V_TRUE;
            end else if (p_q == jcr_pkg::PH_STRING) begin
              p_d = jcr_pkg::PH_STR_END;
              v_d = jcr_pkg::V_TRUE;
            end else begin
              v_d = v_body;
            end
          end
          jcr_pkg::C_ALNUM: begin
            h_d = jcr_pkg::H_LETTER;
            v_d = jcr_pkg::V_TRUE;
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
      default: begin
        // start, control and unused handler codes
        unique case (head_i.cls)
          jcr_pkg::C_LBRACE: begin
            h_d = jcr_pkg::H_LBRACE;
            p_d = jcr_pkg::PH_BEGIN;
            v_d = jcr_pkg::V_TRUE;
          end
          jcr_pkg::C_CTRL: begin
            h_d = jcr_pkg::H_CTRL;
            v_d = jcr_pkg::V_INDET;
          end
          default: v_d = jcr_pkg::V_FALSE;
        endcase
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= jcr_pkg::H_START;
      p_q         <= jcr_pkg::PH_IDLE;
      t_q         <= jcr_pkg::T_NONE;
      v_q         <= jcr_pkg::V_FALSE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        h_q <= h_d;
        p_q <= p_d;
        t_q <= t_d;
        v_q <= v_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = v_q;
  assign phase_o        = p_q;
  assign value_type_o   = t_q;
  assign expect_class_o = h_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(h_q) && $stable(p_q) && $stable(v_q)
                                      && $stable(t_q)))
    else $error("result changed while stalled");

  a_pop_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped beat produced no result");

  a_indet_in_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == jcr_pkg::V_INDET) |-> (h_q == jcr_pkg::H_CTRL))
    else $error("indeterminate verdict outside control handler");

  a_type_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_q != jcr_pkg::T_NONE) |=> (t_q != jcr_pkg::T_NONE))
    else $error("value type cleared");

endmodule

@@ rtl/core/json_char_recognizer_unit.sv @@
// Top level of the flat JSON byte recognizer: front classifier, beat queue, grammar back end.
// One byte is accepted per cycle while the queue is not full and one result beat comes out
// per byte, in order; the sustained rate is one byte per clock while the output is not
// stalled, set by the grammar state update in the back end. An accepted byte is written into
// the queue, then popped by the back end into its result registers on the outputs; a stalled
// output holds it in the queue. The queue of QueueDepth classified beats lets the input keep
// taking bytes while a result waits on a stalled output; in_stall_o rises only when the queue is full.
module json_char_recognizer_unit #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o,
  output logic [4:0] phase_o,
  output logic [1:0] value_type_o,
  output logic [3:0] expect_class_o
);

  jcr_pkg::beat_t push;
  jcr_pkg::beat_t head;
  logic           q_full;
  logic           pop;

  jcr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  jcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  jcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .phase_o        (phase_o),
    .value_type_o   (value_type_o),
    .expect_class_o (expect_class_o)
  );

endmodule
